>>> hdl/rxhd_pkg.sv
package rxhd_pkg;

   localparam int CHAR_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int PLEN_W      = 4;
   localparam int PBYTES_W    = 64;
   localparam int PREFIX_MAX  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_KEY,
      PH_PREFIX,
      PH_TEXT
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PREFIX_LEN   = 1'b0,
      CSR_PREFIX_BYTES = 1'b1
   } csr_index_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_PREFIX = 2'd1;
   localparam status_type ST_KEYLEN = 2'd2;
   localparam status_type ST_HEX    = 2'd3;

   typedef struct packed {
      logic [CHAR_W-1:0] text_byte;
      logic              byte_valid;
      logic              end_of_message;
      status_type        status;
   } result_type;

   typedef struct packed {
      logic                ok;
      logic [NIBBLE_W-1:0] value;
   } nibble_type;

   // ASCII 0-9, A-F and a-f map to their nibble; anything else is flagged.
   function automatic nibble_type hex_decode(input logic [CHAR_W-1:0] c);
      nibble_type n;
      n = '0;
      case (c) inside
         [8'h30:8'h39]: begin
            n.ok    = 1'b1;
            n.value = NIBBLE_W'(c - 8'h30);
         end
         [8'h41:8'h46]: begin
            n.ok    = 1'b1;
            n.value = NIBBLE_W'(c - 8'h37);
         end
         [8'h61:8'h66]: begin
            n.ok    = 1'b1;
            n.value = NIBBLE_W'(c - 8'h57);
         end
         default: begin
            n = '0;
         end
      endcase
      return n;
   endfunction

endpackage

>>> hdl/rxhd_ram.sv
module rxhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rxhd_obuf.sv
module rxhd_obuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rxhd_pkg::result_type   push_result,
   input  logic                   out_ready,
   output logic                   out_valid,
   output rxhd_pkg::result_type   out_result,
   output logic                   full
);
   import rxhd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop = out_valid_ff & out_ready;

   // The skid stage only fills when a result arrives while the output
   // register is held; the input side stops while it is occupied.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_data_ff;
   assign full       = skid_valid_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result while the output register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed while the skid stage is occupied");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && !skid_valid_ff)
      else $error("skid result lost on output transaction");

endmodule

>>> hdl/rxhd_core.sv
module rxhd_core #(
   parameter int MAX_KEY_LEN = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rxhd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rxhd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                in_accept,
   input  logic [rxhd_pkg::CHAR_W-1:0]         hex_char,
   input  logic                                last_char,
   output logic                                out_push,
   output rxhd_pkg::result_type                out_result
);
   import rxhd_pkg::*;

   localparam int KLW = $clog2(MAX_KEY_LEN + 1);
   localparam int KPW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int BCW = (KLW > PLEN_W) ? KLW : PLEN_W;

   logic [PLEN_W-1:0]   prefix_len_ff;
   logic [PBYTES_W-1:0] prefix_bytes_ff;

   phase_type           phase_ff, phase_in;
   logic [NIBBLE_W-1:0] high_ff, high_in;
   logic                pending_ff, pending_in;
   logic [KLW-1:0]      key_length_ff, key_length_in;
   logic [KPW-1:0]      key_pos_ff, key_pos_in;
   logic [BCW-1:0]      count_ff, count_in;
   status_type          fault_ff, fault_in;
   logic                finished_ff, finished_in;

   nibble_type          nib;
   logic [CHAR_W-1:0]   byte_val;
   logic [CHAR_W-1:0]   key_rd_data;
   logic [CHAR_W-1:0]   plain;
   logic [CHAR_W-1:0]   want;
   logic [PLEN_W-1:0]   eff_len;
   logic [BCW-1:0]      count_inc;
   logic [KLW-1:0]      pos_inc;
   status_type          fault;
   status_type          report;
   logic                text_valid;
   logic                text_ok;
   logic                key_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_len_ff   <= '0;
         prefix_bytes_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PREFIX_LEN:   prefix_len_ff   <= csr_wdata[PLEN_W-1:0];
            CSR_PREFIX_BYTES: prefix_bytes_ff <= csr_wdata[PBYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign eff_len   = (prefix_len_ff > PLEN_W'(PREFIX_MAX)) ? PLEN_W'(PREFIX_MAX)
                                                            : prefix_len_ff;
   assign nib       = hex_decode(hex_char);
   assign byte_val  = {high_ff, nib.value};
   assign plain     = byte_val ^ key_rd_data;
   assign want      = prefix_bytes_ff[{count_ff[2:0], 3'b000} +: CHAR_W];
   assign count_inc = count_ff + BCW'(1);
   assign pos_inc   = KLW'(key_pos_ff) + KLW'(1);

   // The key byte for a cipher byte is read when its high nibble arrives,
   // so the registered read data is ready when the low nibble completes it.
   rxhd_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_KEY_LEN)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (count_ff[KPW-1:0]),
      .wr_data (byte_val),
      .rd_en   (in_accept & ~pending_ff),
      .rd_addr (key_pos_ff),
      .rd_data (key_rd_data)
   );

   // Next state
   always_comb begin
      phase_in      = phase_ff;
      high_in       = high_ff;
      pending_in    = pending_ff;
      key_length_in = key_length_ff;
      key_pos_in    = key_pos_ff;
      count_in      = count_ff;
      finished_in   = finished_ff;
      fault         = fault_ff;
      report        = ST_OK;
      text_valid    = 1'b0;
      key_we        = 1'b0;
      if (in_accept) begin
         if (!nib.ok && fault == ST_OK) begin
            fault = ST_HEX;
         end
         if (!pending_ff) begin
            high_in    = nib.value;
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            if (fault == ST_OK) begin
               case (phase_ff)
                  PH_HEADER: begin
                     if (byte_val == '0 || byte_val > CHAR_W'(MAX_KEY_LEN)) begin
                        fault = ST_KEYLEN;
                     end else begin
                        key_length_in = KLW'(byte_val);
                        count_in      = '0;
                        phase_in      = PH_KEY;
                     end
                  end
                  PH_KEY: begin
                     key_we = 1'b1;
                     if (count_inc >= BCW'(key_length_ff)) begin
                        count_in   = '0;
                        key_pos_in = '0;
                        phase_in   = (eff_len == '0) ? PH_TEXT : PH_PREFIX;
                     end else begin
                        count_in = count_inc;
                     end
                  end
                  PH_PREFIX, PH_TEXT: begin
                     key_pos_in = (pos_inc >= key_length_ff) ? '0 : pos_inc[KPW-1:0];
                     if (phase_ff == PH_PREFIX) begin
                        if (plain != want) begin
                           fault = ST_PREFIX;
                        end else begin
                           count_in = count_inc;
                           if (count_inc >= BCW'(eff_len)) begin
                              phase_in = PH_TEXT;
                           end
                        end
                     end else if (!finished_ff) begin
                        if (plain == '0) begin
                           finished_in = 1'b1;
                        end else begin
                           text_valid = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         if (last_char) begin
            if (pending_in && fault == ST_OK) begin
               fault = ST_HEX;
            end
            if (fault == ST_OK) begin
               if (phase_in == PH_HEADER || phase_in == PH_KEY) begin
                  fault = ST_KEYLEN;
               end else if (phase_in == PH_PREFIX) begin
                  fault = ST_PREFIX;
               end
            end
            report        = fault;
            // The message is over: everything but the key store starts afresh.
            phase_in      = PH_HEADER;
            high_in       = '0;
            pending_in    = 1'b0;
            key_length_in = '0;
            key_pos_in    = '0;
            count_in      = '0;
            finished_in   = 1'b0;
            fault         = ST_OK;
         end
      end
      fault_in = fault;
   end

   // Outputs
   always_comb begin
      text_ok                   = text_valid && (!last_char || report == ST_OK);
      out_push                  = in_accept && (text_ok || last_char);
      out_result.text_byte      = text_ok ? plain : '0;
      out_result.byte_valid     = text_ok;
      out_result.end_of_message = last_char;
      out_result.status         = last_char ? report : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         high_ff       <= '0;
         pending_ff    <= 1'b0;
         key_length_ff <= '0;
         key_pos_ff    <= '0;
         count_ff      <= '0;
         fault_ff      <= ST_OK;
         finished_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         high_ff       <= high_in;
         pending_ff    <= pending_in;
         key_length_ff <= key_length_in;
         key_pos_ff    <= key_pos_in;
         count_ff      <= count_in;
         fault_ff      <= fault_in;
         finished_ff   <= finished_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      in_accept && last_char |=> phase_ff == PH_HEADER && !pending_ff && fault_ff == ST_OK)
      else $error("message state not cleared after the final character");

   a_key_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PREFIX || phase_ff == PH_TEXT) |-> KLW'(key_pos_ff) < key_length_ff)
      else $error("key position beyond the key length");

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff != ST_OK && !(in_accept && last_char) |=> fault_ff == $past(fault_ff))
      else $error("fault code changed within a message");

endmodule

>>> hdl/repeating_xor_hex_decoder.sv
// Channel  Direction  tdata           tuser                         tlast
// req      in         hex_char[7:0]   -                             last_char
// rsp      out        text_byte[7:0]  byte_valid, status[1:0]       end_of_message
// csr      in         write enable, register index, 64-bit data; no read-back
//
// One character is taken every cycle while req_tready is high; each result is
// registered in the output stage before it reaches rsp. The key byte is read
// from the key RAM on the high-nibble character and used on the low-nibble one.
// Reset is synchronous; the key RAM is not cleared and needs no sweep.
// A two-entry output stage lets input continue while one result is stalled;
// req_tready falls only when both entries are full.
module repeating_xor_hex_decoder #(
   parameter int MAX_KEY_LEN = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // hex_char[7:0]
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // text_byte[7:0]
   output logic [2:0]                       rsp_tuser,   // byte_valid, status[1:0]
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [rxhd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rxhd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rxhd_pkg::*;

   logic       in_accept;
   logic       push;
   result_type push_result;
   result_type out_result;
   logic       full;

   assign req_tready = ~full;
   assign in_accept  = req_tvalid & req_tready;

   rxhd_core #(
      .MAX_KEY_LEN (MAX_KEY_LEN)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_accept  (in_accept),
      .hex_char   (req_tdata),
      .last_char  (req_tlast),
      .out_push   (push),
      .out_result (push_result)
   );

   rxhd_obuf u_obuf (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_result (push_result),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_result  (out_result),
      .full        (full)
   );

   assign rsp_tdata = out_result.text_byte;
   assign rsp_tuser = {out_result.status, out_result.byte_valid};
   assign rsp_tlast = out_result.end_of_message;

endmodule

>>> verif/tb_repeating_xor_hex_decoder.sv
module tb_repeating_xor_hex_decoder;
   import rxhd_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       pinned;
      status_type pin;
   } probe_type;

   // Opening checks: malformed and short messages, bad key lengths, then one clean message.
   localparam probe_type PROBES [24] = '{
      '{8'h30, 1'b1, 1'b1, ST_HEX},
      '{8'h30, 1'b0, 1'b0, ST_OK},  '{8'h30, 1'b1, 1'b1, ST_KEYLEN},
      '{8'h46, 1'b0, 1'b0, ST_OK},  '{8'h66, 1'b1, 1'b1, ST_KEYLEN},
      '{8'h34, 1'b0, 1'b0, ST_OK},  '{8'h31, 1'b1, 1'b1, ST_KEYLEN},
      '{8'h00, 1'b0, 1'b0, ST_OK},  '{8'h61, 1'b1, 1'b1, ST_HEX},
      '{8'h30, 1'b0, 1'b0, ST_OK},  '{8'h31, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b1, 1'b1, ST_HEX},
      '{8'h30, 1'b0, 1'b0, ST_OK},  '{8'h31, 1'b1, 1'b1, ST_KEYLEN},
      '{8'h30, 1'b0, 1'b0, ST_OK},  '{8'h31, 1'b0, 1'b0, ST_OK},
      '{8'h35, 1'b0, 1'b0, ST_OK},  '{8'h61, 1'b0, 1'b0, ST_OK},
      '{8'h33, 1'b0, 1'b0, ST_OK},  '{8'h62, 1'b0, 1'b0, ST_OK},
      '{8'h63, 1'b0, 1'b0, ST_OK},  '{8'h46, 1'b0, 1'b0, ST_OK},
      '{8'h35, 1'b0, 1'b0, ST_OK},  '{8'h41, 1'b1, 1'b1, ST_OK}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Decoder state as predicted by the testbench.
   logic [3:0]  cfg_prefix_len;
   logic [63:0] cfg_prefix_bytes;
   phase_type   dec_phase;
   logic [3:0]  dec_high;
   logic        dec_pending;
   logic [6:0]  dec_key_len;
   logic [7:0]  dec_key [64];
   logic [6:0]  dec_key_pos;
   logic [6:0]  dec_count;
   status_type  dec_fault;
   logic        dec_done;

   result_type  pending_results [$];
   int          mismatches = 0;
   bit          steady = 1'b0;
   bit          hold_request = 1'b0;

   repeating_xor_hex_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void clear_decoder();
      dec_phase   = PH_HEADER;
      dec_high    = '0;
      dec_pending = 1'b0;
      dec_key_len = '0;
      dec_key_pos = '0;
      dec_count   = '0;
      dec_fault   = ST_OK;
      dec_done    = 1'b0;
   endfunction

   // Takes one whole byte; returns 1 with the plaintext when a text byte comes out.
   function automatic bit absorb_byte(input logic [7:0] b, output logic [7:0] txt);
      logic [7:0] d;
      logic [3:0] eff;
      txt = '0;
      eff = (cfg_prefix_len > 4'd8) ? 4'd8 : cfg_prefix_len;
      if (dec_phase == PH_HEADER) begin
         if (b == 8'd0 || b > 8'd64) begin
            dec_fault = ST_KEYLEN;
         end else begin
            dec_key_len = b[6:0];
            dec_count   = '0;
            dec_phase   = PH_KEY;
         end
         return 1'b0;
      end
      if (dec_phase == PH_KEY) begin
         dec_key[dec_count[5:0]] = b;
         dec_count++;
         if (dec_count >= dec_key_len) begin
            dec_count   = '0;
            dec_key_pos = '0;
            dec_phase   = (eff == 4'd0) ? PH_TEXT : PH_PREFIX;
         end
         return 1'b0;
      end
      d = b ^ dec_key[dec_key_pos[5:0]];
      dec_key_pos++;
      if (dec_key_pos >= dec_key_len) dec_key_pos = '0;
      if (dec_phase == PH_PREFIX) begin
         if (d != cfg_prefix_bytes[8*dec_count[2:0] +: 8]) begin
            dec_fault = ST_PREFIX;
         end else begin
            dec_count++;
            if (dec_count >= eff) dec_phase = PH_TEXT;
         end
         return 1'b0;
      end
      if (dec_done) return 1'b0;
      if (d == 8'd0) begin
         dec_done = 1'b1;
         return 1'b0;
      end
      txt = d;
      return 1'b1;
   endfunction

   function automatic bit decode_char(input logic [7:0] c, input logic last,
                                      output result_type r);
      logic [3:0] nib;
      logic [7:0] txt;
      bit         ok;
      bit         valid;
      ok  = 1'b1;
      nib = '0;
      txt = '0;
      valid = 1'b0;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) nib = c[3:0];
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) nib = c[3:0] + 4'd9;
      else ok = 1'b0;
      if (!ok && dec_fault == ST_OK) dec_fault = ST_HEX;
      if (!dec_pending) begin
         dec_high    = nib;
         dec_pending = 1'b1;
      end else begin
         dec_pending = 1'b0;
         if (dec_fault == ST_OK) valid = absorb_byte({dec_high, nib}, txt);
      end
      if (!last) begin
         r.text_byte  = txt;
         r.byte_valid = valid;
         return valid;
      end
      if (dec_pending && dec_fault == ST_OK) dec_fault = ST_HEX;
      if (dec_fault == ST_OK) begin
         if (dec_phase == PH_HEADER || dec_phase == PH_KEY) dec_fault = ST_KEYLEN;
         else if (dec_phase == PH_PREFIX) dec_fault = ST_PREFIX;
      end
      if (dec_fault == ST_OK && valid) begin
         r.text_byte  = txt;
         r.byte_valid = 1'b1;
      end
      r.end_of_message = 1'b1;
      r.status         = dec_fault;
      clear_decoder();
      return 1'b1;
   endfunction

   function automatic logic [7:0] to_hex(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   // Entered and left at a falling edge. A pinned row carries a hand-worked result.
   task automatic send_char(input logic [7:0] c, input logic last, input logic pinned,
                            input status_type pin);
      result_type r;
      bit         produced;
      if (!steady && $urandom_range(0, 99) < 7) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      produced = decode_char(c, last, r);
      if (pinned) begin
         r = '0;
         r.end_of_message = 1'b1;
         r.status = pin;
         produced = 1'b1;
      end
      if (produced) pending_results.push_back(r);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_PREFIX_LEN) cfg_prefix_len = value[3:0];
      else cfg_prefix_bytes = value;
   endtask

   // Builds one message, mostly well formed, now and then broken, and sends it.
   task automatic send_message(inout int sent);
      logic [7:0] key [$];
      logic [7:0] wire_bytes [$];
      logic [7:0] chars [$];
      logic [7:0] plain;
      logic [7:0] c;
      int         klen, eff, ntext, pos, flaw, roll, wrong_at;
      roll = $urandom_range(0, 99);
      flaw = $urandom_range(0, 99);
      if (roll < 60) klen = $urandom_range(1, 8);
      else if (roll < 85) klen = $urandom_range(9, 63);
      else if (roll < 93) klen = 64;
      else if (roll < 96) klen = 0;
      else klen = $urandom_range(65, 255);
      wire_bytes.push_back(8'(klen));
      if (klen == 0 || klen > 64) begin
         repeat ($urandom_range(0, 6)) wire_bytes.push_back(8'($urandom));
      end else begin
         repeat (klen) begin
            plain = 8'($urandom);
            key.push_back(plain);
            wire_bytes.push_back(plain);
         end
         eff      = (cfg_prefix_len > 4'd8) ? 8 : int'(cfg_prefix_len);
         wrong_at = (flaw < 8 && eff > 0) ? $urandom_range(0, eff - 1) : -1;
         ntext    = $urandom_range(0, 16);
         pos      = 0;
         for (int i = 0; i < eff + ntext; i++) begin
            if (i < eff) plain = cfg_prefix_bytes[8*i +: 8];
            else if ($urandom_range(0, 19) == 0) plain = 8'h00;
            else plain = 8'($urandom_range(1, 255));
            if (i == wrong_at) plain ^= 8'($urandom_range(1, 255));
            wire_bytes.push_back(plain ^ key[pos]);
            pos = (pos + 1) % klen;
         end
      end
      foreach (wire_bytes[i]) begin
         chars.push_back(to_hex(wire_bytes[i][7:4]));
         chars.push_back(to_hex(wire_bytes[i][3:0]));
      end
      if (flaw >= 8 && flaw < 16) begin
         pos = $urandom_range(1, chars.size());
         while (chars.size() > pos) void'(chars.pop_back());
      end else if (flaw < 24) begin
         // Valid hex characters all sit below 0x80, so a random character with bit 7 set spoils one.
         c = 8'($urandom);
         pos = $urandom_range(0, chars.size() - 1);
         chars[pos] = (c[7] == 1'b0) ? (c ^ 8'h80) : c;
      end else if (flaw < 29) begin
         void'(chars.pop_back());
      end else if (flaw < 34) begin
         chars.delete();
         repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom));
      end
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, 1'b0, ST_OK);
      sent += chars.size();
   endtask

   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.text_byte      = rsp_tdata;
         seen.byte_valid     = rsp_tuser[0];
         seen.status         = rsp_tuser[2:1];
         seen.end_of_message = rsp_tlast;
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected transaction: text %h valid %b end %b status %0d",
                        seen.text_byte, seen.byte_valid, seen.end_of_message, seen.status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (seen.text_byte !== want.text_byte || seen.byte_valid !== want.byte_valid ||
                seen.end_of_message !== want.end_of_message || seen.status !== want.status) begin
               if (mismatches < 10)
                  $display("mismatch: expected text %h valid %b end %b status %0d, got %h %b %b %0d",
                           want.text_byte, want.byte_valid, want.end_of_message, want.status,
                           seen.text_byte, seen.byte_valid, seen.end_of_message, seen.status);
               mismatches++;
            end
         end
      end
   end

   // Result side: occasional random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready = 1'b0;
            repeat (150) @(negedge clock);
         end
         rsp_tready = steady || $urandom_range(0, 99) >= 7;
      end
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int         sent;
      logic [3:0] plen;
      logic [63:0] pbytes;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_PREFIX_LEN;
      csr_wdata  = '0;
      cfg_prefix_len   = '0;
      cfg_prefix_bytes = '0;
      foreach (dec_key[i]) dec_key[i] = '0;
      clear_decoder();
      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (PROBES[i])
         send_char(PROBES[i].ch, PROBES[i].last, PROBES[i].pinned, PROBES[i].pin);

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin plen = 4'd0;  pbytes = {$urandom, $urandom}; end
            1: begin plen = 4'd8;  pbytes = '1; end
            2: begin plen = 4'd15; pbytes = {$urandom, $urandom}; end
            3: begin plen = 4'd3;  pbytes = '0; end
            4: begin plen = 4'($urandom_range(1, 7)); pbytes = {$urandom, $urandom}; end
            default: begin plen = 4'd8; pbytes = '0; end
         endcase
         // Only the low four bits of the length register matter.
         write_csr(CSR_PREFIX_LEN, {$urandom, $urandom} & ~64'hF | 64'(plen));
         write_csr(CSR_PREFIX_BYTES, pbytes);
         steady = (p == 3);
         if (p == 1) hold_request = 1'b1;
         sent = 0;
         while (sent < 190) send_message(sent);
      end
      settle();
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
hdl/rxhd_pkg.sv
hdl/rxhd_ram.sv
hdl/rxhd_obuf.sv
hdl/rxhd_core.sv
hdl/repeating_xor_hex_decoder.sv
verif/tb_repeating_xor_hex_decoder.sv
